### hdl/slist_pkg.sv
// ----------------------------------------------------------------------------
// slist_pkg: shared types and constants for the sorted list engine
// Depth, widths, command and status codes, cell control struct.
// ----------------------------------------------------------------------------
package slist_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 5;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } slist_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } slist_status_t;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic wr;    // update this cycle
        logic ins;   // 1: open a slot (insert), 0: close a slot (remove)
    } slist_ctl_t;

endpackage

### hdl/slist_cell.sv
// ----------------------------------------------------------------------------
// slist_cell: one slot of the sorted chain
// Holds one value, compares it with the request value, and keeps, loads the
// request value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module slist_cell
    import slist_pkg::*;
(
    input  logic                     clk,
    input  slist_ctl_t               ctl,
    input  logic                     occupied,
    input  logic signed [DATA_W-1:0] req_value,
    input  logic                     left_lt,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic signed [DATA_W-1:0] val,
    output logic                     lt,
    output logic                     eq
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;

    assign val = val_reg;
    assign lt  = occupied && (val_reg < req_value);
    assign eq  = occupied && (val_reg == req_value);

    always_comb
    begin
        val_next = val_reg;
        if (ctl.wr && !lt)
        begin
            if (ctl.ins)
                val_next = left_lt ? req_value : left_val;
            else
                val_next = right_val;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### hdl/sorted_list_engine.sv
// The result is registered: it is valid in the cycle after a request is accepted.
// Throughput: one request per cycle; a request is taken whenever the result
// register is empty or being drained in the same cycle.
// Every cell compares against the request in parallel and the chain shifts
// by one slot in the same cycle, so no request waits on another.
// Reset: count and result valid clear asynchronously; cell contents do not.
// ----------------------------------------------------------------------------
// sorted_list_engine: sorted store of signed values with insert/remove/get
// A row of DEPTH cells keeps values in ascending order in slots below the
// count. Each cell flags whether its value is below or equal to the request
// value; those flags decide where a slot opens or closes.
// ----------------------------------------------------------------------------
module sorted_list_engine
    import slist_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [POS_W-1:0]         count
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    slist_status_t            status_reg;
    slist_status_t            status_next;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;
    logic [POS_W-1:0]         count_out_reg;
    logic [POS_W-1:0]         count_out_next;

    logic                     accept;
    slist_cmd_t               cmd;
    slist_ctl_t               ctl;
    logic                     full;
    logic                     empty;
    logic                     found;
    logic signed [DATA_W-1:0] get_value;
    logic [POS_CMP_W-1:0]     pos_ext;
    logic [POS_CMP_W-1:0]     cnt_ext;
    logic [POS_CMP_W-1:0]     cnt_next_ext;

    logic signed [DATA_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]         cell_lt;
    logic [DEPTH-1:0]         cell_eq;
    logic [DEPTH-1:0]         cell_occ;

    // result register frees up as it drains
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cmd      = slist_cmd_t'(command);

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign found   = |cell_eq;   // sorted: first equal sits right after the "less" prefix
    assign pos_ext = POS_CMP_W'(position);
    assign cnt_ext = POS_CMP_W'(count_reg);

    assign ctl.wr  = accept && (((cmd == CMD_INSERT) && !full) ||
                                ((cmd == CMD_REMOVE) && found));
    assign ctl.ins = (cmd == CMD_INSERT);

    // ---- cell chain ----
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                     left_lt;
            logic signed [DATA_W-1:0] left_val;
            logic signed [DATA_W-1:0] right_val;

            assign cell_occ[gi] = (POS_CMP_W'(gi) < cnt_ext);

            if (gi == 0)
            begin : g_head
                // nothing to the left: slot 0 takes the new value unless kept
                assign left_lt  = 1'b1;
                assign left_val = value;
            end
            else
            begin : g_body
                assign left_lt  = cell_lt[gi-1];
                assign left_val = cell_val[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                // slot freed at the end; its content no longer counts
                assign right_val = cell_val[gi];
            end
            else
            begin : g_mid
                assign right_val = cell_val[gi+1];
            end

            slist_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (cell_occ[gi]),
                .req_value (value),
                .left_lt   (left_lt),
                .left_val  (left_val),
                .right_val (right_val),
                .val       (cell_val[gi]),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    // get: one-hot select on the 1-based position
    always_comb
    begin
        get_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pos_ext == POS_CMP_W'(i + 1))
                get_value = cell_val[i];
        end
    end

    // ---- next count and result ----
    always_comb
    begin
        count_next      = count_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            CMD_REMOVE:
            begin
                if (found)
                    count_next = count_reg - CNT_W'(1);
                else
                    status_next = ST_NOT_FOUND;
            end
            CMD_GET:
            begin
                if (empty)
                    status_next = ST_NOT_FOUND;
                else if ((pos_ext == '0) || (pos_ext > cnt_ext))
                    status_next = ST_BAD_POS;
                else
                    read_value_next = get_value;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // count field carries the low bits of the count
    assign cnt_next_ext   = POS_CMP_W'(count_next);
    assign count_out_next = cnt_next_ext[POS_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            count_out_reg  <= count_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;

endmodule

### hdl/slist_checker.sv
// ----------------------------------------------------------------------------
// slist_checker: port-level assertions for the sorted list engine
// Watches the request and result channels and checks result consistency.
// ----------------------------------------------------------------------------
module slist_checker
    import slist_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [CMD_W-1:0]         command,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [STAT_W-1:0]        status,
    input logic signed [DATA_W-1:0] read_value,
    input logic [POS_W-1:0]         count
);

    localparam logic [POS_CMP_W-1:0] DEPTH_EXT = POS_CMP_W'(DEPTH);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
        else $error("result changed while stalled");

    // clear shows up next cycle with empty count
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_CLEAR)
        |=> out_valid && (count == '0) && (status == ST_OK))
        else $error("clear result wrong");

    // nonzero read data only on a good get
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> (status == ST_OK))
        else $error("read data with failing status");

    // full only when the store is at depth
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == DEPTH_EXT[POS_W-1:0]))
        else $error("full status with short count");

endmodule

bind sorted_list_engine slist_checker u_slist_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .count      (count)
);
